@@ src/b64x_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and character decode for the base64 XOR field decoder.
// No dependencies.
package b64x_pkg;

  localparam logic [7:0] XOR_MASK     = 8'h43;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_C         = 8'h43;
  localparam logic [2:0] FIELD_CODE   = 3'd2;
  localparam logic [2:0] FIELD_BAR    = 3'd3;
  localparam logic [2:0] FIELD_LAST   = 3'd4;
  localparam logic [5:0] GROUPS_RESET = 6'd20;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CT_NONE   = 2'd0,
    CT_ONE_C  = 2'd1,
    CT_CC     = 2'd2,
    CT_FAILED = 2'd3
  } ct_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] field_index;
    logic       field_end;
    logic       last;
    logic       cue_valid;
    logic [6:0] cue_digit;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [5:0] decode6(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61;
      else if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
      else if (c == 8'h2B || c == 8'h2C) v = 8'd62;
      else if (c == 8'h2F || c == 8'h2D) v = 8'd63;
      return v[5:0];
    end
  endfunction

endpackage

@@ src/base64_xor_field_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the base64 XOR field decoder: input register, decode core, result queue, APB.
// Depends on b64x_pkg, b64x_core, b64x_fifo.
//
// Usage:
//   Input channel: ch with in_valid / in_stall; one scanner character per request.
//   Output channel: data_byte, field_index, field_end, last, cue_valid, cue_digit
//   with out_valid / out_stall; each character gives zero, one or two result requests,
//   the final one marked by last.
//   A character taken at the input is held in the input register, decoded by the core
//   and its results are written into the result queue, from which they are offered.
//   Throughput: one character per cycle while in_stall is low. A character that
//   gives two results still needs two pops at the output.
//   The eight-entry result queue parts the two sides; in_stall rises when the queue
//   might not hold the results of the registered and the next character, so a
//   stalling receiver backs up into the input and nothing is lost.
//   Reset (rst, synchronous) empties the queue, clears the field state and sets
//   max_field_groups to 20. APB: max_field_groups at byte address 0.
//   It is to be written only while the block is idle; the block does not enforce this.
module base64_xor_field_decoder_top import b64x_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [2:0]  field_index,
  output logic        field_end,
  output logic        last,
  output logic        cue_valid,
  output logic [6:0]  cue_digit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           pend;
  logic [7:0]     ch_q;
  logic [5:0]     max_groups;
  push_t          push;
  res_t           head;
  logic [PTR_W:0] level;
  logic           accept;

  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'd0) ? {26'd0, max_groups} : 32'd0;
  assign in_stall = pend ? (level > (PTR_W + 1)'(FIFO_DEPTH - 4))
                         : (level > (PTR_W + 1)'(FIFO_DEPTH - 2));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      max_groups <= GROUPS_RESET;
    end else begin
      pend <= accept;
      if (psel && penable && pwrite && paddr == 3'd0) max_groups <= pwdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ch_q <= ch;
  end

  b64x_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pend),
    .ch         (ch_q),
    .max_groups (max_groups),
    .push       (push)
  );

  b64x_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (!out_stall),
    .not_empty (out_valid),
    .level     (level),
    .head      (head)
  );

  assign data_byte   = head.data_byte;
  assign field_index = head.field_index;
  assign field_end   = head.field_end;
  assign last        = head.last;
  assign cue_valid   = head.cue_valid;
  assign cue_digit   = head.cue_digit;

endmodule

@@ src/b64x_core.sv @@
`timescale 1ns / 1ps
// Decode state and per-character result logic: up to two results per character.
// Depends on b64x_pkg.
module b64x_core import b64x_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [7:0] ch,
  input  logic [5:0] max_groups,
  output push_t      push
);

  logic [1:0] group_pos, group_pos_next;
  logic [5:0] held_bits, held_bits_next;
  logic [5:0] group_count, group_count_next;
  logic [2:0] field_num, field_num_next;
  ct_state_t  ct, ct_next;
  logic       cue_mode, cue_mode_next;
  logic       dot_pending, dot_pending_next;

  function automatic res_t make_res(input logic [7:0] b, input logic fend,
                                    input logic [2:0] fn, input logic cue);
    res_t       r;
    logic       cv;
    logic [7:0] d;
    begin
      cv = cue && fn == FIELD_BAR && b >= 8'd32 && b <= 8'd126;
      d  = b - 8'd32;
      r.data_byte   = b;
      r.field_index = fn;
      r.field_end   = fend;
      r.last        = 1'b0;
      r.cue_valid   = cv;
      r.cue_digit   = cv ? d[6:0] : 7'd0;
      return r;
    end
  endfunction

  function automatic ct_state_t ct_upd(input ct_state_t c, input logic [2:0] fn,
                                       input logic [7:0] b);
    ct_state_t o;
    begin
      o = c;
      if (fn == FIELD_CODE) begin
        case (c)
          CT_NONE:  o = (b == CH_C) ? CT_ONE_C : CT_FAILED;
          CT_ONE_C: o = (b == CH_C) ? CT_CC : CT_FAILED;
          default:  o = c;
        endcase
      end
      return o;
    end
  endfunction

  logic [5:0] v;
  logic [5:0] limit;
  logic [6:0] cnt;
  logic [7:0] b0, b1;
  logic       do_end;
  ct_state_t  ct_mid;

  always_comb begin
    group_pos_next   = group_pos;
    held_bits_next   = held_bits;
    group_count_next = group_count;
    field_num_next   = field_num;
    ct_next          = ct;
    cue_mode_next    = cue_mode;
    dot_pending_next = dot_pending;
    push             = '0;
    v                = decode6(ch);
    limit            = (max_groups == 6'd0) ? 6'd1 : max_groups;
    cnt              = {1'b0, group_count} + 7'd1;
    b0               = 8'd0;
    b1               = 8'd0;
    do_end           = 1'b0;
    ct_mid           = ct;

    if (item_valid) begin
      dot_pending_next = 1'b0;
      if (dot_pending && ch == CH_DOT) begin
        // swallowed after a forced end
      end else if (ch == CH_DOT || ch == CH_NEWLINE) begin
        case (group_pos)
          2'd1: begin
            b0 = {held_bits, 2'b00} ^ XOR_MASK;
            push.n  = 2'd2;
            push.r0 = make_res(b0, 1'b0, field_num, cue_mode);
            push.r1 = make_res(8'd0, 1'b1, field_num, cue_mode);
            push.r1.last = 1'b1;
            ct_mid = ct_upd(ct_upd(ct, field_num, b0), field_num, 8'd0);
          end
          2'd2: begin
            b0 = (held_bits != 6'd0) ? ({held_bits[3:0], 4'b0000} ^ XOR_MASK) : 8'd0;
            push.n  = 2'd1;
            push.r0 = make_res(b0, 1'b1, field_num, cue_mode);
            push.r0.last = 1'b1;
            ct_mid = ct_upd(ct, field_num, b0);
          end
          2'd3: begin
            b0 = (held_bits != 6'd0) ? ({held_bits[1:0], 6'b000000} ^ XOR_MASK) : 8'd0;
            push.n  = 2'd1;
            push.r0 = make_res(b0, 1'b1, field_num, cue_mode);
            push.r0.last = 1'b1;
            ct_mid = ct_upd(ct, field_num, b0);
          end
          default: ct_mid = ct;
        endcase
        if (ch == CH_NEWLINE) begin
          group_pos_next   = 2'd0;
          held_bits_next   = 6'd0;
          group_count_next = 6'd0;
          field_num_next   = 3'd0;
          ct_next          = CT_NONE;
          cue_mode_next    = 1'b0;
        end else begin
          ct_next = ct_mid;
          do_end  = 1'b1;
        end
      end else begin
        case (group_pos)
          2'd0: begin
            held_bits_next = v;
            group_pos_next = 2'd1;
          end
          2'd1: begin
            held_bits_next = {2'b00, v[3:0]};
            group_pos_next = 2'd2;
            b1 = {held_bits, v[5:4]} ^ XOR_MASK;
            push.n  = 2'd1;
            push.r0 = make_res(b1, 1'b0, field_num, cue_mode);
            push.r0.last = 1'b1;
            ct_next = ct_upd(ct, field_num, b1);
          end
          2'd2: begin
            held_bits_next = {4'b0000, v[1:0]};
            group_pos_next = 2'd3;
            b1 = {held_bits[3:0], v[5:2]} ^ XOR_MASK;
            push.n  = 2'd1;
            push.r0 = make_res(b1, 1'b0, field_num, cue_mode);
            push.r0.last = 1'b1;
            ct_next = ct_upd(ct, field_num, b1);
          end
          default: begin
            held_bits_next   = 6'd0;
            group_pos_next   = 2'd0;
            group_count_next = cnt[5:0];
            b1 = {held_bits[1:0], v} ^ XOR_MASK;
            push.n  = 2'd1;
            push.r0 = make_res(b1, cnt >= {1'b0, limit}, field_num, cue_mode);
            push.r0.last = 1'b1;
            ct_next = ct_upd(ct, field_num, b1);
            ct_mid  = ct_next;
            if (cnt >= {1'b0, limit}) begin
              do_end           = 1'b1;
              dot_pending_next = 1'b1;
            end
          end
        endcase
      end

      if (do_end) begin
        if (field_num == FIELD_CODE) cue_mode_next = (ct_mid == CT_CC);
        if (field_num < FIELD_LAST) field_num_next = field_num + 3'd1;
        if (field_num + 3'd1 == FIELD_CODE) ct_next = CT_NONE;
        group_pos_next   = 2'd0;
        held_bits_next   = 6'd0;
        group_count_next = 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos   <= 2'd0;
      held_bits   <= 6'd0;
      group_count <= 6'd0;
      field_num   <= 3'd0;
      ct          <= CT_NONE;
      cue_mode    <= 1'b0;
      dot_pending <= 1'b0;
    end else begin
      group_pos   <= group_pos_next;
      held_bits   <= held_bits_next;
      group_count <= group_count_next;
      field_num   <= field_num_next;
      ct          <= ct_next;
      cue_mode    <= cue_mode_next;
      dot_pending <= dot_pending_next;
    end
  end

endmodule

@@ src/b64x_fifo.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one.
// Depends on b64x_pkg.
module b64x_fifo import b64x_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic             pop,
  output logic             not_empty,
  output logic [PTR_W:0]   level,
  output res_t             head
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_pop;

  assign not_empty = (count != '0);
  assign level     = count;
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + PTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.n);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W + 1)'(push.n) - (PTR_W + 1)'(do_pop);
    end
  end

endmodule

@@ src/b64x_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the base64 XOR field decoder, bound to the top level.
// Depends on base64_xor_field_decoder_top.
module b64x_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic [2:0] field_index,
  input logic       cue_valid,
  input logic [6:0] cue_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(data_byte) && $stable(field_index))
    else $error("stalled result changed");

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> field_index <= 3'd4)
    else $error("field index past trailer");

  a_cue_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && cue_valid |-> field_index == 3'd3 && {1'b0, cue_digit} == data_byte - 8'd32)
    else $error("cue digit inconsistent");

  a_cue_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cue_valid |-> cue_digit == 7'd0)
    else $error("cue digit set without cue");

endmodule

bind base64_xor_field_decoder_top b64x_checker u_b64x_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .data_byte   (data_byte),
  .field_index (field_index),
  .cue_valid   (cue_valid),
  .cue_digit   (cue_digit)
);
